// ===== src/pirdr_pkg.sv =====
`timescale 1ns / 1ps

package pirdr_pkg;

    // Byte store geometry: eight byte-wide banks, one byte lane each.
    localparam int STORE_BYTES = 4096;
    localparam int NUM_BANKS   = 8;
    localparam int BANK_DEPTH  = STORE_BYTES / NUM_BANKS;
    localparam int ROW_W       = $clog2(BANK_DEPTH);
    // Internal byte address width, wide enough for any store size and offset.
    localparam int ADDR_W      = 21;

    // Field widths.
    localparam int IDX_W   = 15;
    localparam int BADDR_W = 12;
    localparam int VALUE_W = 64;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_WIDTH_CODE  = 1'b0,
        CFG_BASE_OFFSET = 1'b1
    } t_cfg_index;

    // Element width codes.
    typedef enum logic [3:0] {
        W1  = 4'd0,
        W2  = 4'd1,
        W4  = 4'd2,
        W8  = 4'd3,
        W12 = 4'd4,
        W16 = 4'd5,
        W20 = 4'd6,
        W24 = 4'd7,
        W28 = 4'd8,
        W32 = 4'd9,
        W40 = 4'd10,
        W48 = 4'd11,
        W56 = 4'd12,
        W64 = 4'd13
    } t_width_code;

    // Control word that travels with a read through the memory stage.
    typedef struct packed {
        logic        rd;
        logic        oor;
        logic [3:0]  wcode;
        logic [2:0]  lo;
        logic [2:0]  idx_lo;
    } t_rd_ctl;

    // Bits per element; zero for unsupported codes.
    function automatic logic [6:0] width_bits(input logic [3:0] code);
        logic [6:0] w;
        unique case (code)
            W1:      w = 7'd1;
            W2:      w = 7'd2;
            W4:      w = 7'd4;
            W8:      w = 7'd8;
            W12:     w = 7'd12;
            W16:     w = 7'd16;
            W20:     w = 7'd20;
            W24:     w = 7'd24;
            W28:     w = 7'd28;
            W32:     w = 7'd32;
            W40:     w = 7'd40;
            W48:     w = 7'd48;
            W56:     w = 7'd56;
            W64:     w = 7'd64;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

    // Bytes touched by one access of the given width.
    function automatic logic [3:0] access_bytes(input logic [6:0] w);
        logic [3:0] n;
        if (w <= 7'd8) begin
            n = 4'd1;
        end else if (w <= 7'd16) begin
            n = 4'd2;
        end else if (w <= 7'd32) begin
            n = 4'd4;
        end else begin
            n = 4'd8;
        end
        return n;
    endfunction

endpackage

// ===== src/pirdr_ram.sv =====
`timescale 1ns / 1ps

module pirdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pirdr_addr.sv =====
`timescale 1ns / 1ps

module pirdr_addr
    import pirdr_pkg::*;
(
    input  logic [IDX_W-1:0]   i_idx,
    input  logic [3:0]         i_wcode,
    input  logic [BADDR_W-1:0] i_base,
    output logic [ROW_W-1:0]   o_row [NUM_BANKS],
    output logic [2:0]         o_lo,
    output logic               o_oor
);

    logic [6:0]        w;
    logic [3:0]        nbytes;
    logic [IDX_W+6:0]  prod;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] last;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  row_next;

    // Start byte of the element: base plus the bit offset divided by eight.
    always_comb begin
        w      = width_bits(i_wcode);
        nbytes = access_bytes(w);
        prod   = (IDX_W + 7)'(i_idx) * (IDX_W + 7)'(w);
        addr   = ADDR_W'(i_base) + ADDR_W'(prod[IDX_W+6:3]);
        last   = addr + ADDR_W'(nbytes);
        o_oor  = (w != 7'd0) && (last > ADDR_W'(STORE_BYTES));
        o_lo   = addr[2:0];
    end

    // Banks below the start lane hold the wrapped bytes on the next row.
    assign row      = addr[ROW_W+2:3];
    assign row_next = row + ROW_W'(1);

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            o_row[b] = (3'(b) < addr[2:0]) ? row_next : row;
        end
    end

endmodule

// ===== src/pirdr_unpack.sv =====
`timescale 1ns / 1ps

module pirdr_unpack
    import pirdr_pkg::*;
(
    input  logic [7:0]         i_bank [NUM_BANKS],
    input  t_rd_ctl            i_ctl,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_oor
);

    logic [VALUE_W-1:0] win;
    logic [VALUE_W-1:0] val;
    logic [7:0]         b0;
    logic [2:0]         nib;
    logic [2:0]         sel;

    // Rotate the bank lanes so the start byte lands on the top of the window.
    always_comb begin
        win = '0;
        for (int k = 0; k < NUM_BANKS; k++) begin
            sel = i_ctl.lo + 3'(k);
            win[VALUE_W-1-8*k -: 8] = i_bank[sel];
        end
    end

    assign b0  = win[63:56];
    assign nib = i_ctl.idx_lo[0] ? 3'd0 : 3'd4;

    // Shift and mask by element width; even indices take the upper nibble.
    always_comb begin
        val = '0;
        case (i_ctl.wcode)
            W1:  val = VALUE_W'(b0[~i_ctl.idx_lo]);
            W2:  val = VALUE_W'(2'(b0 >> {~i_ctl.idx_lo[1:0], 1'b0}));
            W4:  val = VALUE_W'(4'(b0 >> nib));
            W8:  val = VALUE_W'(b0);
            W12: val = VALUE_W'(12'(win[63:48] >> nib));
            W16: val = VALUE_W'(win[63:48]);
            W20: val = VALUE_W'(20'(win[63:40] >> nib));
            W24: val = VALUE_W'(win[63:40]);
            W28: val = VALUE_W'(28'(win[63:32] >> nib));
            W32: val = VALUE_W'(win[63:32]);
            W40: val = VALUE_W'(win[63:24]);
            W48: val = VALUE_W'(win[63:16]);
            W56: val = VALUE_W'(win[63:8]);
            W64: val = win;
            default: val = '0;
        endcase
    end

    assign o_value = (i_ctl.rd && !i_ctl.oor) ? val : '0;
    assign o_oor   = i_ctl.rd && i_ctl.oor;

endmodule

// ===== src/packed_integer_array_reader_top.sv =====
`timescale 1ns / 1ps
// Pipeline: stage one, then the bank read with stage two, then the output register.
// Throughput: one word per cycle, read or write, while no stall holds the pipeline;
// a read fetches up to eight bytes in one access of the eight byte-lane memory banks.
// Reset: synchronous, active low; clears the pipeline valids and both config registers.
// The byte store is not cleared and must be written before it is read.

module packed_integer_array_reader_top
    import pirdr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data,
    // Input channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    input  logic [BADDR_W-1:0]  i_byte_address,
    input  logic [7:0]          i_byte_value,
    input  logic [IDX_W-1:0]    i_element_index,
    // Output channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VALUE_W-1:0]  o_element_value,
    output logic                o_out_of_range
);

    logic [3:0]         r_width_code;
    logic [BADDR_W-1:0] r_base_offset;

    logic               r_v1;
    logic               r_mode1;
    logic [BADDR_W-1:0] r_waddr1;
    logic [7:0]         r_wval1;
    logic [IDX_W-1:0]   r_idx1;

    logic               r_v2;
    t_rd_ctl            r_ctl2;
    t_rd_ctl            n_ctl2;

    logic               r_ov;
    logic [VALUE_W-1:0] r_value;
    logic               r_oor;

    logic               en_out;
    logic               en2;
    logic               en1;
    logic               wr_fire;
    logic [ADDR_W-1:0]  waddr_ext;

    logic [ROW_W-1:0]   rd_row [NUM_BANKS];
    logic [2:0]         rd_lo;
    logic               rd_oor;
    logic [7:0]         bank_data [NUM_BANKS];
    logic [VALUE_W-1:0] unp_value;
    logic               unp_oor;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_code  <= '0;
            r_base_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH_CODE:  r_width_code  <= i_cfg_data[3:0];
                CFG_BASE_OFFSET: r_base_offset <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // Each stage moves when the stage after it is empty or moving.
    assign en_out     = !r_ov || !i_out_stall;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;

    // Stage one: registered input word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_mode1  <= i_mode;
            r_waddr1 <= i_byte_address;
            r_wval1  <= i_byte_value;
            r_idx1   <= i_element_index;
        end
    end

    // Address generation for the banked read.
    pirdr_addr u_addr (
        .i_idx   (r_idx1),
        .i_wcode (r_width_code),
        .i_base  (r_base_offset),
        .o_row   (rd_row),
        .o_lo    (rd_lo),
        .o_oor   (rd_oor)
    );

    // A write lands in its bank as the word leaves stage one.
    assign waddr_ext = ADDR_W'(r_waddr1);
    assign wr_fire   = en2 && r_v1 && !r_mode1 && (waddr_ext < ADDR_W'(STORE_BYTES));

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        pirdr_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_fire && (waddr_ext[2:0] == 3'(b))),
            .i_waddr (waddr_ext[ROW_W+2:3]),
            .i_wdata (r_wval1),
            .i_re    (en2),
            .i_raddr (rd_row[b]),
            .o_rdata (bank_data[b])
        );
    end

    // Stage two: control that travels beside the memory read.
    always_comb begin
        n_ctl2.rd     = r_mode1;
        n_ctl2.oor    = rd_oor;
        n_ctl2.wcode  = r_width_code;
        n_ctl2.lo     = rd_lo;
        n_ctl2.idx_lo = r_idx1[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ctl2 <= n_ctl2;
        end
    end

    // Byte alignment and field extraction.
    pirdr_unpack u_unpack (
        .i_bank  (bank_data),
        .i_ctl   (r_ctl2),
        .o_value (unp_value),
        .o_oor   (unp_oor)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_v2) begin
            r_value <= unp_value;
            r_oor   <= unp_oor;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_element_value = r_value;
    assign o_out_of_range  = r_oor;

endmodule
